// File: src/ptw_pkg.sv
package ptw_pkg;

	// Request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_XLATE = 2'd1;
	localparam logic [1:0] MODE_UNMAP = 2'd2;

	// Mapping sizes
	localparam logic [1:0] SIZE_4K   = 2'd0;
	localparam logic [1:0] SIZE_2M   = 2'd1;
	localparam logic [1:0] SIZE_1G   = 2'd2;
	localparam logic [1:0] SIZE_NONE = 2'd3;

	// Result status
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOMAP = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// Width of a descriptor word index built from a 48-bit byte address
	localparam int WIDX_W = 45;

	typedef struct packed {
		logic [1:0]  mode;
		logic [47:0] root_addr;
		logic [47:0] vaddr;
		logic [47:0] word_addr;
		logic [63:0] word_data;
	} req_t;

	typedef struct packed {
		logic [47:0] phys_addr;
		logic [1:0]  map_size;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		RES_DONE,
		RES_NOMAP,
		RES_RANGE,
		RES_PAGE,
		RES_BLK2M,
		RES_BLK1G
	} res_kind_t;

	typedef struct packed {
		logic      load_req;
		logic      clr_we;
		logic      rd_en;
		logic      rd_root;
		logic [1:0] lvl;
		logic      wr_word;
		logic      wr_zero;
		logic      res_load;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic       clr_done;
		logic       wr_ok;
		logic       lk_ok;
		logic       d_valid;
		logic       d_table;
		logic       out_free;
		logic [1:0] mode;
	} sts_t;

endpackage

// File: src/ptw_dp.sv
module ptw_dp #(
	parameter int MEM_WORDS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ptw_pkg::req_t req,
	input  ptw_pkg::cmd_t cmd,
	output ptw_pkg::sts_t sts,
	input  logic          rsp_ready,
	output logic          rsp_valid,
	output ptw_pkg::rsp_t rsp
);
	import ptw_pkg::*;

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic [63:0] mem [MEM_WORDS];

	req_t            req_q;
	logic [63:0]     rd_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   leaf_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;
	rsp_t            rsp_n;
	logic [8:0]      idx;
	logic [35:0]     base;
	logic [WIDX_W-1:0] lk_wi;
	logic [WIDX_W-1:0] wr_wi;

	// Table index for the level being looked up
	always_comb begin
		case (cmd.lvl)
			2'd0:    idx = req_q.vaddr[47:39];
			2'd1:    idx = req_q.vaddr[38:30];
			2'd2:    idx = req_q.vaddr[29:21];
			default: idx = req_q.vaddr[20:12];
		endcase
	end

	assign base  = cmd.rd_root ? req_q.root_addr[47:12] : rd_q[47:12];
	assign lk_wi = {base, idx};
	assign wr_wi = req_q.word_addr[47:3];

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			mem[clr_q] <= '0;
		end else if (cmd.wr_word) begin
			mem[wr_wi[AW-1:0]] <= req_q.word_data;
		end else if (cmd.wr_zero) begin
			mem[leaf_q] <= '0;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[lk_wi[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		if (cmd.rd_en) begin
			leaf_q <= lk_wi[AW-1:0];
		end
		if (cmd.res_load) begin
			rsp_q <= rsp_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Compose the result from the last descriptor read
	always_comb begin
		rsp_n = '{phys_addr: '0, map_size: SIZE_NONE, status: STAT_OK};
		case (cmd.res_kind)
			RES_DONE:  rsp_n.status = STAT_OK;
			RES_NOMAP: rsp_n.status = STAT_NOMAP;
			RES_RANGE: rsp_n.status = STAT_RANGE;
			RES_PAGE: begin
				rsp_n.phys_addr = {rd_q[47:12], req_q.vaddr[11:0]};
				rsp_n.map_size  = SIZE_4K;
			end
			RES_BLK2M: begin
				rsp_n.phys_addr = {rd_q[47:21], req_q.vaddr[20:0]};
				rsp_n.map_size  = SIZE_2M;
			end
			RES_BLK1G: begin
				rsp_n.phys_addr = {rd_q[47:30], req_q.vaddr[29:0]};
				rsp_n.map_size  = SIZE_1G;
			end
			default: rsp_n.status = STAT_OK;
		endcase
	end

	assign sts.clr_done = (clr_q == AW'(MEM_WORDS - 1));
	assign sts.wr_ok    = (wr_wi < WIDX_W'(MEM_WORDS));
	assign sts.lk_ok    = (lk_wi < WIDX_W'(MEM_WORDS));
	assign sts.d_valid  = rd_q[0];
	assign sts.d_table  = rd_q[1];
	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign sts.mode     = req_q.mode;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: src/ptw_ctrl.sv
module ptw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptw_pkg::sts_t sts,
	output ptw_pkg::cmd_t cmd
);
	import ptw_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_WALK,
		S_HOLD
	} state_t;

	state_t    state_q, state_n;
	logic [1:0] lvl_q, lvl_n;
	res_kind_t kind_q, kind_n;
	logic      fin;
	res_kind_t fkind;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.lvl      = lvl_q;
		cmd.res_kind = kind_q;
		state_n      = state_q;
		lvl_n        = lvl_q;
		kind_n       = kind_q;
		fin          = 1'b0;
		fkind        = RES_DONE;

		case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_done) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_n      = S_START;
				end
			end
			S_START: begin
				case (sts.mode)
					MODE_WRITE: begin
						cmd.wr_word = sts.wr_ok;
						fin         = 1'b1;
						fkind       = sts.wr_ok ? RES_DONE : RES_RANGE;
					end
					MODE_XLATE, MODE_UNMAP: begin
						cmd.rd_root = 1'b1;
						cmd.lvl     = 2'd0;
						if (sts.lk_ok) begin
							cmd.rd_en = 1'b1;
							lvl_n     = 2'd0;
							state_n   = S_WALK;
						end else begin
							fin   = 1'b1;
							fkind = RES_RANGE;
						end
					end
					default: begin
						fin   = 1'b1;
						fkind = RES_DONE;
					end
				endcase
			end
			S_WALK: begin
				if (lvl_q == 2'd3) begin
					fin = 1'b1;
					if (sts.mode == MODE_XLATE) begin
						fkind = (sts.d_valid && sts.d_table) ? RES_PAGE : RES_NOMAP;
					end else begin
						cmd.wr_zero = 1'b1;
						fkind       = sts.d_valid ? RES_DONE : RES_NOMAP;
					end
				end else if (!sts.d_valid) begin
					fin   = 1'b1;
					fkind = RES_NOMAP;
				end else if (!sts.d_table) begin
					fin = 1'b1;
					if (sts.mode == MODE_XLATE && lvl_q == 2'd1) begin
						fkind = RES_BLK1G;
					end else if (sts.mode == MODE_XLATE && lvl_q == 2'd2) begin
						fkind = RES_BLK2M;
					end else begin
						fkind = RES_NOMAP;
					end
				end else begin
					cmd.lvl = lvl_q + 2'd1;
					if (sts.lk_ok) begin
						cmd.rd_en = 1'b1;
						lvl_n     = lvl_q + 2'd1;
					end else begin
						fin   = 1'b1;
						fkind = RES_RANGE;
					end
				end
			end
			S_HOLD: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase

		// Hand the result to the output register, or park it while that is full
		if (fin) begin
			if (sts.out_free) begin
				cmd.res_load = 1'b1;
				cmd.res_kind = fkind;
				state_n      = S_IDLE;
			end else begin
				kind_n  = fkind;
				state_n = S_HOLD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			lvl_q   <= 2'd0;
			kind_q  <= RES_DONE;
		end else begin
			state_q <= state_n;
			lvl_q   <= lvl_n;
			kind_q  <= kind_n;
		end
	end

endmodule

// File: src/page_table_walk_translate.sv
// Four-level page table walker over a local descriptor memory of MEM_WORDS
// 64-bit words (4 KB granule, 48-bit addresses, 9-bit indices per level).
// Each request is a table word write, a translate or a leaf unmap, and each
// gives exactly one response; any other mode is answered as done. After reset
// the memory is cleared one word per cycle, with req_ready low until the clear
// pass is done. A write is done from the request register and answered via the
// response register; a translate or unmap also reads one descriptor per level,
// since each level's table address comes out of the previous read of the
// descriptor memory; a block, an invalid descriptor or an out-of-range table
// address ends a walk early. One request is in flight at a time; a finished
// response waits in an output register, and the next request is accepted as
// soon as the response has been handed to it.
module page_table_walk_translate #(
	parameter int MEM_WORDS = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptw_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ptw_pkg::rsp_t rsp
);
	import ptw_pkg::*;

	// Commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	// Sequencer: clear pass, request intake, level-by-level walk, response handoff
	ptw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: request register, descriptor memory, range checks, response register
	ptw_dp #(
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: src/ptw_chk.sv
module ptw_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ptw_pkg::rsp_t rsp
);
	import ptw_pkg::*;

	// Hold a stalled response
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response dropped or changed while stalled");

	// Take one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in flight");

	// A mapping size only comes with success
	a_size_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.map_size != SIZE_NONE |-> rsp.status == STAT_OK)
		else $error("mapping size reported on a failed request");

	// No mapping means no address
	a_pa_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.map_size == SIZE_NONE |-> rsp.phys_addr == '0)
		else $error("address reported without a mapping");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == STAT_OK || rsp.status == STAT_NOMAP
			|| rsp.status == STAT_RANGE)
		else $error("undefined response status");

endmodule

bind page_table_walk_translate ptw_chk u_ptw_chk (.*);
